>>> src/mte_pkg.sv
// ============================================================================
// mte_pkg: shared types and constants of the multi-tap echo unit
// Sizes, register indexes and the beat structures between the controller,
// the channel lanes and the merge stage.
// ============================================================================
package mte_pkg;

    localparam int MAX_DELAY = 32768;
    localparam int NUM_TAPS  = 4;
    localparam int CHANNELS  = 2;

    // Only two sample fields exist, so at most two lanes are built.
    localparam int LANES     = (CHANNELS > 2) ? 2 : CHANNELS;
    localparam int TAP_SLOTS = 4;

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 15;
    localparam int GAIN_W    = 16;
    localparam int FRAMES_W  = 16;
    localparam int FRAC_BITS = 14;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int ACC_W     = PROD_W + $clog2(NUM_TAPS + 1);
    localparam int ADDR_W    = $clog2(MAX_DELAY);
    localparam int TAP_W     = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

    localparam int SAT_HI    = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAT_LO    = -(1 << (SAMPLE_W - 1));

    localparam int OUT_DEPTH = 2;
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam int NUM_REGS  = 2 * TAP_SLOTS;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_TAP_DELAY_0 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_TAP_DELAY_1 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_TAP_DELAY_2 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_TAP_DELAY_3 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_TAP_GAIN_0  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_TAP_GAIN_1  = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_TAP_GAIN_2  = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_TAP_GAIN_3  = REG_IDX_W'(7);

    // One tap of one frame, as the controller hands it to every lane.
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic                     tap_on;
        logic                     bypass;
        logic [ADDR_W-1:0]        rd_addr;
        logic signed [GAIN_W-1:0] gain;
        logic                     wr;
        logic [ADDR_W-1:0]        wr_addr;
    } mte_issue_t;

    // Finished Q.14 sum of one lane.
    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } mte_lane_out_t;

endpackage

>>> src/mte_if.sv
// ============================================================================
// mte_in_if / mte_out_if: frame and result channels
// Valid/ready channels carrying one stereo frame or one mixed result per beat.
// ============================================================================
interface mte_in_if;
    import mte_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       first_frame;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;

    modport source (output valid, output first_frame, output sample_left,
                    output sample_right, input ready);
    modport sink   (input valid, input first_frame, input sample_left,
                    input sample_right, output ready);
endinterface

interface mte_out_if;
    import mte_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       clipped;

    modport source (output valid, output out_left, output out_right,
                    output clipped, input ready);
    modport sink   (input valid, input out_left, input out_right,
                    input clipped, output ready);
endinterface

>>> src/mte_ctrl.sv
// ============================================================================
// mte_ctrl: register file and tap sequencer
// Holds the tap registers, the write pointer and the frame count, and issues
// one tap per cycle to all lanes.
// ============================================================================
module mte_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mte_pkg::PADDR_W-1:0]  paddr,
    input  logic [mte_pkg::PDATA_W-1:0]  pwdata,
    output logic [mte_pkg::PDATA_W-1:0]  prdata,
    input  logic                         in_valid,
    input  logic                         first_frame,
    output logic                         in_ready,
    input  logic                         out_pop,
    output mte_pkg::mte_issue_t          issue
);
    import mte_pkg::*;

    typedef struct packed {
        logic                     tap_on;
        logic                     bypass;
        logic [ADDR_W-1:0]        rd_addr;
        logic signed [GAIN_W-1:0] gain;
    } tap_info_t;

    logic [DELAY_W-1:0]        delay_reg [TAP_SLOTS];
    logic signed [GAIN_W-1:0]  gain_reg  [TAP_SLOTS];
    logic [ADDR_W-1:0]         slot_reg;
    logic [ADDR_W-1:0]         slot_next;
    logic [FRAMES_W-1:0]       frames_reg;
    logic [FRAMES_W-1:0]       frames_eff;
    logic                      busy_reg;
    logic [TAP_W-1:0]          phase_reg;
    logic [CNT_W-1:0]          cnt_reg;
    tap_info_t                 queue_reg [NUM_TAPS];
    tap_info_t                 info      [NUM_TAPS];
    tap_info_t                 cur_tap;
    logic                      accept;
    logic                      wr_cfg;
    logic [REG_IDX_W-1:0]      reg_idx;
    logic                      last_tap;

    assign reg_idx  = paddr[PADDR_W-1:2];
    assign wr_cfg   = psel && penable && pwrite;
    assign in_ready = !busy_reg && (cnt_reg < CNT_W'(OUT_DEPTH));
    assign accept   = in_valid && in_ready;

    assign frames_eff = first_frame ? '0 : frames_reg;
    assign slot_next  = (32'(slot_reg) == 32'(MAX_DELAY - 1)) ? '0 : slot_reg + 1'b1;

    // Per-tap gating and history address for the frame being accepted.
    always_comb
    begin
        logic [31:0] d32;
        logic [31:0] s32;
        logic [31:0] diff;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            d32  = 32'(delay_reg[k]);
            s32  = 32'(slot_reg);
            diff = (s32 >= d32) ? (s32 - d32) : (s32 + 32'(MAX_DELAY) - d32);
            info[k].tap_on  = (gain_reg[k] != '0) && (d32 < 32'(MAX_DELAY))
                              && (FRAMES_W'(delay_reg[k]) <= frames_eff);
            info[k].bypass  = (delay_reg[k] == '0);
            info[k].rd_addr = diff[ADDR_W-1:0];
            info[k].gain    = gain_reg[k];
        end
    end

    assign cur_tap  = busy_reg ? queue_reg[0] : info[0];
    assign last_tap = busy_reg ? (phase_reg == TAP_W'(NUM_TAPS - 1)) : (NUM_TAPS == 1);

    always_comb
    begin
        issue.valid   = accept || busy_reg;
        issue.first   = accept;
        issue.last    = last_tap;
        issue.tap_on  = cur_tap.tap_on;
        issue.bypass  = cur_tap.bypass;
        issue.rd_addr = cur_tap.rd_addr;
        issue.gain    = cur_tap.gain;
        issue.wr      = accept;
        issue.wr_addr = slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAP_SLOTS; k++)
            begin
                delay_reg[k] <= '0;
                gain_reg[k]  <= '0;
            end
            slot_reg   <= '0;
            frames_reg <= '0;
            busy_reg   <= 1'b0;
            phase_reg  <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_cfg)
            begin
                case (reg_idx)
                    REG_TAP_DELAY_0: delay_reg[0] <= pwdata[DELAY_W-1:0];
                    REG_TAP_DELAY_1: delay_reg[1] <= pwdata[DELAY_W-1:0];
                    REG_TAP_DELAY_2: delay_reg[2] <= pwdata[DELAY_W-1:0];
                    REG_TAP_DELAY_3: delay_reg[3] <= pwdata[DELAY_W-1:0];
                    REG_TAP_GAIN_0:  gain_reg[0]  <= pwdata[GAIN_W-1:0];
                    REG_TAP_GAIN_1:  gain_reg[1]  <= pwdata[GAIN_W-1:0];
                    REG_TAP_GAIN_2:  gain_reg[2]  <= pwdata[GAIN_W-1:0];
                    REG_TAP_GAIN_3:  gain_reg[3]  <= pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                slot_reg   <= slot_next;
                frames_reg <= (frames_eff == {FRAMES_W{1'b1}}) ? frames_eff
                                                                : frames_eff + 1'b1;
            end

            if (accept && (NUM_TAPS > 1))
            begin
                busy_reg  <= 1'b1;
                phase_reg <= TAP_W'(1);
            end
            else if (busy_reg)
            begin
                if (last_tap)
                begin
                    busy_reg <= 1'b0;
                end
                phase_reg <= phase_reg + 1'b1;
            end

            cnt_reg <= cnt_reg + CNT_W'(accept) - CNT_W'(out_pop);
        end
    end

    // Remaining taps of the frame wait in a short shift line.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            if (accept)
            begin
                queue_reg[k] <= (k + 1 < NUM_TAPS) ? info[(k + 1) % NUM_TAPS] : info[k];
            end
            else if (busy_reg && (k + 1 < NUM_TAPS))
            begin
                queue_reg[k] <= queue_reg[(k + 1) % NUM_TAPS];
            end
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TAP_DELAY_0: prdata = PDATA_W'(delay_reg[0]);
            REG_TAP_DELAY_1: prdata = PDATA_W'(delay_reg[1]);
            REG_TAP_DELAY_2: prdata = PDATA_W'(delay_reg[2]);
            REG_TAP_DELAY_3: prdata = PDATA_W'(delay_reg[3]);
            REG_TAP_GAIN_0:  prdata = PDATA_W'(unsigned'(gain_reg[0]));
            REG_TAP_GAIN_1:  prdata = PDATA_W'(unsigned'(gain_reg[1]));
            REG_TAP_GAIN_2:  prdata = PDATA_W'(unsigned'(gain_reg[2]));
            REG_TAP_GAIN_3:  prdata = PDATA_W'(unsigned'(gain_reg[3]));
            default:         prdata = '0;
        endcase
    end

endmodule

>>> src/mte_lane.sv
// ============================================================================
// mte_lane: one channel of the echo
// History memory of the channel, one tap read per cycle, multiply and
// accumulate of the scaled taps onto the current sample in Q.14.
// ============================================================================
module mte_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mte_pkg::mte_issue_t           issue,
    input  logic signed [mte_pkg::SAMPLE_W-1:0] sample,
    output mte_pkg::mte_lane_out_t        lane_out
);
    import mte_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_mem [MAX_DELAY];
    logic signed [SAMPLE_W-1:0] rd_q_reg;
    logic signed [SAMPLE_W-1:0] cur_reg;
    logic                       rd_en;

    logic                       r_valid_reg;
    logic                       r_first_reg;
    logic                       r_last_reg;
    logic                       r_on_reg;
    logic                       r_bypass_reg;
    logic signed [GAIN_W-1:0]   r_gain_reg;

    logic                       p_valid_reg;
    logic                       p_first_reg;
    logic                       p_last_reg;
    logic signed [PROD_W-1:0]   p_prod_reg;
    logic signed [SAMPLE_W-1:0] p_cur_reg;

    logic signed [SAMPLE_W-1:0] operand;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       done_reg;

    // A zero delay takes the current sample, so the memory is never read at
    // the slot written in the same cycle.
    assign rd_en = issue.valid && issue.tap_on && !issue.bypass;

    always_ff @(posedge clk)
    begin
        if (issue.wr)
        begin
            hist_mem[issue.wr_addr] <= sample;
            cur_reg                 <= sample;
        end
        if (rd_en)
        begin
            rd_q_reg <= hist_mem[issue.rd_addr];
        end
    end

    assign operand = r_bypass_reg ? cur_reg : rd_q_reg;
    assign prod    = r_on_reg ? PROD_W'(r_gain_reg * operand) : '0;

    assign acc_next = (p_first_reg ? (ACC_W'(p_cur_reg) <<< FRAC_BITS) : acc_reg)
                      + ACC_W'(p_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            r_valid_reg <= issue.valid;
            p_valid_reg <= r_valid_reg;
            done_reg    <= p_valid_reg && p_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_first_reg  <= issue.first;
        r_last_reg   <= issue.last;
        r_on_reg     <= issue.tap_on;
        r_bypass_reg <= issue.bypass;
        r_gain_reg   <= issue.gain;

        p_first_reg  <= r_first_reg;
        p_last_reg   <= r_last_reg;
        p_prod_reg   <= prod;
        p_cur_reg    <= cur_reg;

        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign lane_out.done = done_reg;
    assign lane_out.acc  = acc_reg;

endmodule

>>> src/mte_merge.sv
// ============================================================================
// mte_merge: rounding, saturation and result buffer
// Rounds each lane's sum half away from zero, saturates it, combines the clip
// flags and holds up to two results for the output channel.
// ============================================================================
module mte_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mte_pkg::mte_lane_out_t        lane_out [mte_pkg::LANES],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [mte_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [mte_pkg::SAMPLE_W-1:0] out_right,
    output logic                          clipped
);
    import mte_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] HALF_LO = ACC_W'((1 << (FRAC_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] LIM_HI  = ACC_W'(SAT_HI);
    localparam logic signed [ACC_W-1:0] LIM_LO  = ACC_W'(SAT_LO);

    typedef struct packed {
        logic                       clip;
        logic signed [SAMPLE_W-1:0] value;
    } lane_res_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       clip;
    } entry_t;

    function automatic lane_res_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        lane_res_t               res;
        rnd = (acc + (acc[ACC_W-1] ? HALF_LO : HALF)) >>> FRAC_BITS;
        if (rnd > LIM_HI)
        begin
            res.clip  = 1'b1;
            res.value = SAMPLE_W'(SAT_HI);
        end
        else if (rnd < LIM_LO)
        begin
            res.clip  = 1'b1;
            res.value = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            res.clip  = 1'b0;
            res.value = rnd[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    lane_res_t            res [LANES];
    entry_t               new_entry;
    entry_t               buf_reg [OUT_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 push;
    logic                 pop;

    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            res[c] = round_sat(lane_out[c].acc);
        end
    end

    always_comb
    begin
        new_entry.left  = res[0].value;
        new_entry.right = '0;
        new_entry.clip  = res[0].clip;
        if (LANES > 1)
        begin
            new_entry.right = res[LANES - 1].value;
            new_entry.clip  = res[0].clip || res[LANES - 1].clip;
        end
    end

    // All lanes run in lockstep, so lane zero marks the beat for all of them.
    assign push      = lane_out[0].done;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == OUT_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == OUT_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign out_left  = buf_reg[rd_ptr_reg].left;
    assign out_right = buf_reg[rd_ptr_reg].right;
    assign clipped   = buf_reg[rd_ptr_reg].clip;

endmodule

>>> src/multi_tap_echo_unit.sv
// ============================================================================
// multi_tap_echo_unit: stereo multi-tap feed-forward echo
// Adds up to four delayed, gain-scaled input samples to each channel of a
// stereo frame, rounds and saturates the result.
//
//   Channel   Direction  Beat contents
//   --------  ---------  ---------------------------------------------------
//   frame     in         first_frame, sample_left, sample_right
//   result    out        out_left, out_right, clipped
//   APB       in/out     tap_delay_0..3 at 0x00..0x0C, tap_gain_0..3 at 0x10..0x1C
//
// Each lane's history memory has one read port and reads one tap per cycle,
// so the taps of a frame are issued one after another and the next frame is
// accepted only once the last tap has been issued. After reset the history
// holds no defined data and needs no clearing pass; taps are gated by the
// frame count. A two-entry result buffer absorbs output stalls, and frame
// ready drops while two results are outstanding.
// ============================================================================
module multi_tap_echo_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mte_pkg::PADDR_W-1:0] paddr,
    input  logic [mte_pkg::PDATA_W-1:0] pwdata,
    output logic [mte_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    mte_in_if.sink                      frame,
    mte_out_if.source                   result
);
    import mte_pkg::*;

    mte_issue_t    issue;
    mte_lane_out_t lane_out [LANES];
    logic          in_ready;

    assign pready      = 1'b1;
    assign frame.ready = in_ready;

    mte_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .in_valid    (frame.valid),
        .first_frame (frame.first_frame),
        .in_ready    (in_ready),
        .out_pop     (result.valid && result.ready),
        .issue       (issue)
    );

    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        logic signed [SAMPLE_W-1:0] lane_sample;

        if (c == 0)
        begin : g_left
            assign lane_sample = frame.sample_left;
        end
        else
        begin : g_right
            assign lane_sample = frame.sample_right;
        end

        mte_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .issue    (issue),
            .sample   (lane_sample),
            .lane_out (lane_out[c])
        );
    end

    mte_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_out  (lane_out),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_left  (result.out_left),
        .out_right (result.out_right),
        .clipped   (result.clipped)
    );

endmodule
